>>> sv/ffra_pkg.sv
// Shared types and constants for the first-fit range allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

    // Bitmap word geometry
    localparam int WORD_W  = 32;
    localparam int WORD_LW = 5;

    // Field widths
    localparam int OPC_W   = 1;
    localparam int SLOT_W  = 10;
    localparam int LEN_W   = 11;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 11;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPC_W-1:0] OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE         = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALLOC_FAIL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FREE_IGNORED = 2'd2;

    // Slot count after reset
    localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [SLOT_W-1:0] start_slot;
        logic [LEN_W-1:0]  run_length;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [STAT_W-1:0] status;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/ffra_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ffra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/first_fit_range_allocator_core.sv
// Top level of the first-fit range allocator: control, scan and bitmap update.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//  cfg     | input     | i_cfg_we                | i_cfg_data (slot_count)
//
// One item at a time. An allocate of nonzero length scans the bitmap one
// 32-slot word per cycle through the RAM read port, then updates the words of
// the run, one per cycle, reading each word and writing it back. A free in
// range goes straight to the update. S_OUT then loads the result into the
// output register once it is free. After reset a clearing pass writes every
// word, with o_in_stall high. A new item is taken while the last result waits.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_range_allocator_core #(
    parameter int SLOTS = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire ffra_pkg::t_in_item        i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output ffra_pkg::t_out_item            o_out_item,
    input  wire logic                      i_cfg_we,
    input  wire logic [ffra_pkg::CNT_W-1:0] i_cfg_data
);

    import ffra_pkg::*;

    localparam int WORDS = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int POS_W = AW + WORD_LW;
    localparam int CMP_W = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_slot_count;
    logic [AW:0]         r_uw;
    logic [AW-1:0]       r_wa;
    logic                r_udv;
    logic [LEN_W-1:0]    r_run;
    logic [LEN_W-1:0]    r_len;
    logic [POS_W-1:0]    r_lo;
    logic [POS_W-1:0]    r_hi;
    logic                r_set;
    t_out_item           r_res;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [CMP_W-1:0]    limit_c;
    logic                in_acc;
    logic [WORD_W-1:0]   used_eff;
    logic [WORD_W-1:0]   hit;
    logic [WORD_LW-1:0]  hit_idx;
    logic                any_hit;
    logic [LEN_W-1:0]    run_next;
    logic [CMP_W-1:0]    hit_pos;
    logic [CMP_W-1:0]    lo_c;
    logic [CMP_W-1:0]    next_base;
    logic [CMP_W-1:0]    free_end;
    logic [WORD_W-1:0]   upd_mask;
    logic [WORD_W-1:0]   upd_data;
    logic                rd_more;

    // Bitmap storage, one word of used bits per entry
    ffra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Active limit = min(slot_count, SLOTS)
    assign limit_c = (CMP_W'(r_slot_count) < CMP_W'(SLOTS)) ?
                     CMP_W'(r_slot_count) : CMP_W'(SLOTS);

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Scan of one word: slot 0 and slots at or past the limit count as used
    always_comb begin
        logic [CMP_W-1:0]   pos;
        logic [WORD_LW-1:0] lastp;
        logic               found;
        logic [LEN_W:0]     run_i;
        used_eff = '0;
        hit      = '0;
        run_next = '0;
        for (int i = 0; i < WORD_W; i++) begin
            pos = CMP_W'({r_uw[AW-1:0], WORD_LW'(i)});
            used_eff[i] = ram_rdata[i] || (pos == '0) || (pos >= limit_c);
        end
        // Run length ending at each bit, from the nearest used bit below it
        for (int i = 0; i < WORD_W; i++) begin
            found = 1'b0;
            lastp = '0;
            for (int j = 0; j <= i; j++) begin
                if (used_eff[j]) begin
                    found = 1'b1;
                    lastp = WORD_LW'(j);
                end
            end
            run_i = found ? ((LEN_W + 1)'(i) - (LEN_W + 1)'(lastp)) :
                            ((LEN_W + 1)'(r_run) + (LEN_W + 1)'(i + 1));
            hit[i] = !used_eff[i] && (run_i == {1'b0, r_len});
            if (i == WORD_W - 1) begin
                run_next = run_i[LEN_W-1:0];
            end
        end
    end

    // Lowest hit wins
    always_comb begin
        hit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = WORD_LW'(i);
            end
        end
    end

    assign any_hit   = |hit;
    assign hit_pos   = CMP_W'({r_uw[AW-1:0], hit_idx});
    assign lo_c      = hit_pos + CMP_W'(1) - CMP_W'(r_len);
    // First slot of the following word, without wrapping past the last word
    assign next_base = (CMP_W'(r_uw) + CMP_W'(1)) << WORD_LW;

    // End of a free run, clipped at the limit
    always_comb begin
        logic [CMP_W-1:0] sum;
        sum      = CMP_W'(i_in_item.start_slot) + CMP_W'(i_in_item.run_length);
        free_end = (sum < limit_c) ? sum : limit_c;
    end

    // Read-modify-write of one word of the run
    always_comb begin
        logic [POS_W-1:0] pos;
        upd_mask = '0;
        for (int i = 0; i < WORD_W; i++) begin
            pos = {r_wa, WORD_LW'(i)};
            upd_mask[i] = (pos >= r_lo) && (pos <= r_hi);
        end
        upd_data = r_set ? (ram_rdata | upd_mask) : (ram_rdata & ~upd_mask);
    end

    assign rd_more = (r_uw <= {1'b0, r_hi[POS_W-1:WORD_LW]});

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = upd_data;
        ram_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_uw[AW-1:0];
                ram_wdata = (r_uw == '0) ? WORD_W'(1) : '0;
            end
            S_SCAN: begin
                ram_raddr = r_uw[AW-1:0] + AW'(1);
            end
            S_UPD: begin
                ram_we    = r_udv;
                ram_raddr = r_uw[AW-1:0];
            end
            S_IDLE,
            S_OUT: begin
                ram_raddr = '0;
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= SLOT_COUNT_RST;
        end else if (i_cfg_we) begin
            r_slot_count <= i_cfg_data;
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_uw        <= '0;
            r_udv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Result taken downstream; S_OUT reloads the register itself
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_uw <= r_uw + (AW + 1)'(1);
                    if (r_uw == (AW + 1)'(WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_len <= i_in_item.run_length;
                        if (i_in_item.opcode == OP_ALLOC) begin
                            if (i_in_item.run_length == '0) begin
                                r_res   <= '{slot_index: '0, status: ST_ALLOC_FAIL};
                                r_state <= S_OUT;
                            end else begin
                                r_uw    <= '0;
                                r_run   <= '0;
                                r_state <= S_SCAN;
                            end
                        end else begin
                            if ((i_in_item.run_length == '0) ||
                                (CMP_W'(i_in_item.start_slot) >= limit_c)) begin
                                r_res   <= '{slot_index: '0, status: ST_FREE_IGNORED};
                                r_state <= S_OUT;
                            end else begin
                                r_lo    <= POS_W'(i_in_item.start_slot);
                                r_hi    <= POS_W'(free_end - CMP_W'(1));
                                r_set   <= 1'b0;
                                r_uw    <= (AW + 1)'(i_in_item.start_slot >> WORD_LW);
                                r_udv   <= 1'b0;
                                r_res   <= '{slot_index: '0, status: ST_DONE};
                                r_state <= S_UPD;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (any_hit) begin
                        r_lo    <= POS_W'(lo_c);
                        r_hi    <= POS_W'(hit_pos);
                        r_set   <= 1'b1;
                        r_uw    <= (AW + 1)'(lo_c >> WORD_LW);
                        r_udv   <= 1'b0;
                        r_res   <= '{slot_index: lo_c[SLOT_W-1:0], status: ST_DONE};
                        r_state <= S_UPD;
                    end else if (next_base >= limit_c) begin
                        r_res   <= '{slot_index: '0, status: ST_ALLOC_FAIL};
                        r_state <= S_OUT;
                    end else begin
                        r_uw  <= r_uw + (AW + 1)'(1);
                        r_run <= run_next;
                    end
                end
                S_UPD: begin
                    // Read word r_uw while writing back the one read before
                    if (rd_more) begin
                        r_uw <= r_uw + (AW + 1)'(1);
                        r_wa <= r_uw[AW-1:0];
                    end
                    r_udv <= rd_more;
                    if (!rd_more && !r_udv) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_item  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/ffra_checker.sv
// Port-level checker for the first-fit range allocator, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ffra_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire ffra_pkg::t_out_item o_out_item
);

    import ffra_pkg::*;

    // A stalled result stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed or dropped");

    // Only defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == ST_DONE ||
                         o_out_item.status == ST_ALLOC_FAIL ||
                         o_out_item.status == ST_FREE_IGNORED))
        else $error("undefined status code");

    // Index is zero unless an item reports done
    a_fail_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_DONE |-> o_out_item.slot_index == '0)
        else $error("nonzero index on failed item");

    // One item at a time: the input stalls after every accepted item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while busy");

    // Reset leaves no result pending and the input stalled
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output valid or input open right after reset");

endmodule

bind first_fit_range_allocator_core ffra_checker u_ffra_checker (.*);

`default_nettype wire
